FILE: rtl/snpm_pkg.sv
package snpm_pkg;

	// Defaults of the module parameters.
	localparam int BLOOM_SIZE_DEF       = 65536;
	localparam int BLOOM_HASHES_DEF     = 4;
	localparam int SIGNATURE_BITS_DEF   = 256;
	localparam int SIGNATURE_HASHES_DEF = 3;

	// Place slot count is tied to the 3-bit and 4-bit place ports.
	localparam int PLACE_SLOTS = 6;

	// Both the Bloom filter and the place store are organized in 64-bit words.
	localparam int WORD_BITS = 64;

	localparam logic [63:0] BLOOM_STEP = 64'h0000_0100_0000_01B3;
	localparam logic [63:0] SIG_STEP   = 64'hD6E8_FEB8_6659_FD93;
	localparam logic [63:0] MIX_MULT   = 64'hFF51_AFD7_ED55_8CCD;

	// Per-hash salts: the step constant times (k + 1), wrapping at 64 bits.
	localparam logic [63:0] BLOOM_SALT [8] = '{
		BLOOM_STEP * 64'd1, BLOOM_STEP * 64'd2, BLOOM_STEP * 64'd3, BLOOM_STEP * 64'd4,
		BLOOM_STEP * 64'd5, BLOOM_STEP * 64'd6, BLOOM_STEP * 64'd7, BLOOM_STEP * 64'd8
	};
	localparam logic [63:0] SIG_SALT [8] = '{
		SIG_STEP * 64'd1, SIG_STEP * 64'd2, SIG_STEP * 64'd3, SIG_STEP * 64'd4,
		SIG_STEP * 64'd5, SIG_STEP * 64'd6, SIG_STEP * 64'd7, SIG_STEP * 64'd8
	};

	// Configuration register indexes.
	localparam logic [7:0] REG_MATCH_PERCENT = 8'd0;
	localparam logic [7:0] REG_KNOWN_MIN     = 8'd1;
	localparam logic [7:0] REG_MIN_WIFI      = 8'd2;
	localparam logic [7:0] REG_AVG_SHIFT     = 8'd3;

	localparam logic [6:0] MATCH_PERCENT_RST = 7'd55;
	localparam logic [7:0] KNOWN_MIN_RST     = 8'd3;
	localparam logic [7:0] MIN_WIFI_RST      = 8'd2;
	localparam logic [3:0] AVG_SHIFT_RST     = 4'd6;

	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	function automatic logic [6:0] pop64(input logic [63:0] v);
		logic [6:0] c;
		c = '0;
		for (int i = 0; i < 64; i++) begin
			c = c + 7'(v[i]);
		end
		return c;
	endfunction

endpackage

FILE: rtl/snpm_ram.sv
module snpm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/scan_novelty_and_place_matcher_core.sv
// Scan novelty detector and place matcher.
//
// Input items (in_valid / in_ready) carry one device key hash each and are
// grouped into scans; the item with last_in_scan set closes the scan. An item
// without an observation only acts through its last_in_scan flag. Each closed
// scan yields one result item on out_valid / out_ready; other items yield none.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); the user
// writes it while the block is idle (not enforced); unknown indexes are ignored.
//
// Each observation runs its hashes one after another through a single 32x32
// multiplier (three partial products per 64-bit mix): each hash steps through
// PRE, MUL0, MUL1, MUL2 and POST, and a Bloom hash adds BCHK for the Bloom
// read-modify-write. A wifi observation runs its signature hashes after its
// Bloom hashes. Closing a scan walks the stored places word by word in the
// place memory and runs a bit-serial divider for each place, with SW signature
// words per place and NW divider bits. After reset the Bloom memory is cleared
// word by word (BLOOM_SIZE/64 words, 1024 by default) while in_ready is held
// low. The result is held in an output register: new input items are still
// taken while it waits, and only the next scan close stalls until out_ready
// takes the pending result.
module scan_novelty_and_place_matcher_core
	import snpm_pkg::*;
#(
	parameter int BLOOM_SIZE       = BLOOM_SIZE_DEF,
	parameter int BLOOM_HASHES     = BLOOM_HASHES_DEF,
	parameter int SIGNATURE_BITS   = SIGNATURE_BITS_DEF,
	parameter int SIGNATURE_HASHES = SIGNATURE_HASHES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_write,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] key_hash,
	input  logic        is_wifi,
	input  logic        has_observation,
	input  logic        last_in_scan,

	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [3:0] place_index,
	output logic [2:0]  places_used,
	output logic [6:0]  similarity,
	output logic        known_place,
	output logic        fresh_place,
	output logic [15:0] wifi_count,
	output logic [15:0] other_count,
	output logic [15:0] novel_count,
	output logic [31:0] unique_estimate,
	output logic [25:0] average_total,
	output logic [25:0] average_wifi,
	output logic [25:0] average_other
);

	// Derived sizes.
	localparam int BDEPTH = BLOOM_SIZE / WORD_BITS;
	localparam int BAW    = $clog2(BDEPTH);
	localparam int BIW    = $clog2(BLOOM_SIZE);
	localparam int SIW    = $clog2(SIGNATURE_BITS);
	localparam int SW     = SIGNATURE_BITS / WORD_BITS;
	localparam int WW     = (SW > 1) ? $clog2(SW) : 1;
	localparam int SLW    = $clog2(PLACE_SLOTS);
	localparam int PDEPTH = PLACE_SLOTS * SW;
	localparam int PAW    = $clog2(PDEPTH);
	localparam int PW     = $clog2(SIGNATURE_BITS + 1);
	localparam int NW     = $clog2(SIGNATURE_BITS * 100 + 1);
	localparam int DCW    = $clog2(NW);
	localparam int HKW    = $clog2(BLOOM_HASHES + SIGNATURE_HASHES + 1);

	localparam logic [4:0] ST_CLR    = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_PRE    = 5'd2;
	localparam logic [4:0] ST_MUL0   = 5'd3;
	localparam logic [4:0] ST_MUL1   = 5'd4;
	localparam logic [4:0] ST_MUL2   = 5'd5;
	localparam logic [4:0] ST_POST   = 5'd6;
	localparam logic [4:0] ST_BCHK   = 5'd7;
	localparam logic [4:0] ST_OBS    = 5'd8;
	localparam logic [4:0] ST_FOLD   = 5'd9;
	localparam logic [4:0] ST_WPC    = 5'd10;
	localparam logic [4:0] ST_PRD    = 5'd11;
	localparam logic [4:0] ST_PACC   = 5'd12;
	localparam logic [4:0] ST_DIV    = 5'd13;
	localparam logic [4:0] ST_CMP    = 5'd14;
	localparam logic [4:0] ST_DECIDE = 5'd15;
	localparam logic [4:0] ST_LRU    = 5'd16;
	localparam logic [4:0] ST_MRD    = 5'd17;
	localparam logic [4:0] ST_MWR    = 5'd18;
	localparam logic [4:0] ST_UPD    = 5'd19;
	localparam logic [4:0] ST_AVG    = 5'd20;
	localparam logic [4:0] ST_EMIT   = 5'd21;

	logic [4:0] state_q;

	// Configuration registers.
	logic [6:0] match_pct_q;
	logic [7:0] known_min_q;
	logic [7:0] min_wifi_q;
	logic [3:0] avg_shift_q;

	// Item being worked on.
	logic [63:0]    h_q;
	logic           wifi_q;
	logic           last_q;
	logic [HKW-1:0] hk_q;
	logic [63:0]    a_q;
	logic [63:0]    acc_q;
	logic           novel_q;
	logic [BAW-1:0] baddr_q;
	logic [5:0]     bbit_q;
	logic [BAW-1:0] clr_q;

	// Scan and running state.
	logic [SIGNATURE_BITS-1:0] win_q;
	logic [15:0] scan_wifi_q;
	logic [15:0] scan_other_q;
	logic [15:0] scan_novel_q;
	logic [31:0] novel_total_q;
	logic [25:0] avg_q [3];
	logic [31:0] cnt_q [PLACE_SLOTS];
	logic [31:0] lu_q [PLACE_SLOTS];
	logic [31:0] use_seq_q;
	logic [2:0]  used_q;
	logic [3:0]  cur_slot_q;
	logic [6:0]  sim_q;
	logic        known_q;
	logic        new_q;

	// Place matching.
	logic [WW-1:0]  w_q;
	logic [SLW-1:0] slot_q;
	logic [PW-1:0]  wpc_q;
	logic [PW-1:0]  both_q;
	logic [NW-1:0]  div_num_q;
	logic [PW:0]    div_rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic           best_valid_q;
	logic [6:0]     best_c_q;
	logic [SLW-1:0] best_i_q;
	logic [31:0]    oldest_q;
	logic [SLW-1:0] lru_i_q;
	logic [SLW-1:0] idx_q;
	logic           newp_q;

	// Output register.
	logic        out_valid_q;
	logic [3:0]  o_place_q;
	logic [2:0]  o_used_q;
	logic [6:0]  o_sim_q;
	logic        o_known_q;
	logic        o_new_q;
	logic [15:0] o_wifi_q;
	logic [15:0] o_other_q;
	logic [15:0] o_novel_q;
	logic [31:0] o_uniq_q;
	logic [25:0] o_avg_q [3];

	// Hash datapath.
	logic           is_bloom;
	logic [2:0]     bk;
	logic [2:0]     sk;
	logic [63:0]    salted;
	logic [63:0]    pre;
	logic [63:0]    post;
	logic [31:0]    mul_a;
	logic [31:0]    mul_b;
	logic [63:0]    prod;
	logic [HKW-1:0] hash_count;
	logic           more_hashes;

	assign is_bloom    = hk_q < HKW'(BLOOM_HASHES);
	assign bk          = hk_q[2:0];
	assign sk          = 3'(hk_q - HKW'(BLOOM_HASHES));
	assign salted      = h_q ^ (is_bloom ? BLOOM_SALT[bk] : SIG_SALT[sk]);
	assign pre         = is_bloom ? (salted ^ (salted >> 33)) : (salted ^ (salted >> 32));
	assign post        = is_bloom ? (acc_q ^ (acc_q >> 33)) : (acc_q ^ (acc_q >> 29));
	assign hash_count  = HKW'(BLOOM_HASHES) + (wifi_q ? HKW'(SIGNATURE_HASHES) : HKW'(0));
	assign more_hashes = (hk_q + HKW'(1)) < hash_count;

	// Low 64 bits of a_q * MIX_MULT from three 32x32 partial products.
	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = a_q[63:32];
				mul_b = MIX_MULT[31:0];
			end
			ST_MUL2: begin
				mul_a = a_q[31:0];
				mul_b = MIX_MULT[63:32];
			end
			default: begin
				mul_a = a_q[31:0];
				mul_b = MIX_MULT[31:0];
			end
		endcase
	end
	assign prod = 64'(mul_a) * 64'(mul_b);

	// Bloom memory.
	logic           b_we;
	logic [BAW-1:0] b_addr;
	logic [63:0]    b_wdata;
	logic [63:0]    b_rdata;

	always_comb begin
		b_we    = 1'b0;
		b_addr  = baddr_q;
		b_wdata = b_rdata | (64'd1 << bbit_q);
		case (state_q)
			ST_CLR: begin
				b_we    = 1'b1;
				b_addr  = clr_q;
				b_wdata = '0;
			end
			ST_POST: begin
				b_addr = post[BIW-1:6];
			end
			ST_BCHK: begin
				b_we = 1'b1;
			end
			default: begin
				b_we = 1'b0;
			end
		endcase
	end

	snpm_ram #(.WIDTH(WORD_BITS), .DEPTH(BDEPTH)) u_bloom (
		.clk   (clk),
		.we    (b_we),
		.addr  (b_addr),
		.wdata (b_wdata),
		.rdata (b_rdata)
	);

	// Place signature memory, slot-major.
	logic           p_we;
	logic [PAW-1:0] p_addr;
	logic [63:0]    p_wdata;
	logic [63:0]    p_rdata;
	logic [63:0]    win_word;

	assign win_word = win_q[32'(w_q) * WORD_BITS +: WORD_BITS];
	assign p_we     = (state_q == ST_MWR);
	assign p_addr   = ((state_q == ST_MRD) || (state_q == ST_MWR))
		? PAW'(PAW'(idx_q) * PAW'(SW) + PAW'(w_q))
		: PAW'(PAW'(slot_q) * PAW'(SW) + PAW'(w_q));
	assign p_wdata  = (newp_q ? 64'd0 : p_rdata) | win_word;

	snpm_ram #(.WIDTH(WORD_BITS), .DEPTH(PDEPTH)) u_place (
		.clk   (clk),
		.we    (p_we),
		.addr  (p_addr),
		.wdata (p_wdata),
		.rdata (p_rdata)
	);

	// Matching helpers.
	logic           w_last;
	logic [PW-1:0]  both_nx;
	logic [PW:0]    rem_nx;
	logic [6:0]     cur_c;
	logic           lru_take;
	logic [SLW-1:0] lru_final;
	logic [31:0]    cnt_nx;

	assign w_last    = (w_q == WW'(SW - 1));
	assign both_nx   = both_q + PW'(pop64(win_word & p_rdata));
	assign rem_nx    = {div_rem_q[PW-1:0], div_num_q[NW-1]};
	assign cur_c     = div_num_q[6:0];
	assign lru_take  = lu_q[slot_q] < oldest_q;
	assign lru_final = lru_take ? slot_q : lru_i_q;
	assign cnt_nx    = (newp_q ? 32'd0 : cnt_q[idx_q]) + 32'd1;

	// Scan totals and average updates.
	logic [16:0] total_raw;
	logic [15:0] total_sat;
	logic [15:0] sample [3];
	logic [25:0] avg_nx [3];

	assign total_raw = 17'(scan_wifi_q) + 17'(scan_other_q);
	assign total_sat = total_raw[16] ? CNT_MAX : total_raw[15:0];
	assign sample[0] = total_sat;
	assign sample[1] = scan_wifi_q;
	assign sample[2] = scan_other_q;

	// A negative step rounds toward minus infinity through the arithmetic shift.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic signed [27:0] d;
			logic signed [27:0] s;
			d = signed'(28'(26'(sample[j]) * 26'd1000)) - signed'(28'(avg_q[j]));
			s = d >>> avg_shift_q;
			avg_nx[j] = 26'(signed'(28'(avg_q[j])) + s);
		end
	end

	// The result is posted once the output register is free or being emptied.
	logic emit_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			clr_q         <= '0;
			match_pct_q   <= MATCH_PERCENT_RST;
			known_min_q   <= KNOWN_MIN_RST;
			min_wifi_q    <= MIN_WIFI_RST;
			avg_shift_q   <= AVG_SHIFT_RST;
			win_q         <= '0;
			scan_wifi_q   <= '0;
			scan_other_q  <= '0;
			scan_novel_q  <= '0;
			novel_total_q <= '0;
			for (int j = 0; j < 3; j++) begin
				avg_q[j] <= '0;
			end
			use_seq_q     <= '0;
			used_q        <= '0;
			cur_slot_q    <= 4'hF;
			sim_q         <= '0;
			known_q       <= 1'b0;
			new_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MATCH_PERCENT: match_pct_q <= cfg_data[6:0];
					REG_KNOWN_MIN:     known_min_q <= cfg_data;
					REG_MIN_WIFI:      min_wifi_q  <= cfg_data;
					REG_AVG_SHIFT:     avg_shift_q <= cfg_data[3:0];
					default:           ;
				endcase
			end

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + BAW'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						h_q     <= key_hash;
						wifi_q  <= is_wifi;
						last_q  <= last_in_scan;
						hk_q    <= '0;
						novel_q <= 1'b0;
						if (has_observation) begin
							state_q <= ST_PRE;
						end else if (last_in_scan) begin
							state_q <= ST_FOLD;
						end
					end
				end
				ST_PRE: begin
					a_q     <= pre;
					state_q <= ST_MUL0;
				end
				ST_MUL0: begin
					acc_q   <= prod;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					acc_q   <= acc_q + {prod[31:0], 32'd0};
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					acc_q   <= acc_q + {prod[31:0], 32'd0};
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (is_bloom) begin
						baddr_q <= post[BIW-1:6];
						bbit_q  <= post[5:0];
						state_q <= ST_BCHK;
					end else begin
						win_q[post[SIW-1:0]] <= 1'b1;
						hk_q    <= hk_q + HKW'(1);
						state_q <= more_hashes ? ST_PRE : ST_OBS;
					end
				end
				ST_BCHK: begin
					if (!b_rdata[bbit_q]) begin
						novel_q <= 1'b1;
					end
					hk_q    <= hk_q + HKW'(1);
					state_q <= more_hashes ? ST_PRE : ST_OBS;
				end
				ST_OBS: begin
					if (novel_q) begin
						if (scan_novel_q != CNT_MAX) begin
							scan_novel_q <= scan_novel_q + 16'd1;
						end
						novel_total_q <= novel_total_q + 32'd1;
					end
					if (wifi_q) begin
						if (scan_wifi_q != CNT_MAX) begin
							scan_wifi_q <= scan_wifi_q + 16'd1;
						end
					end else if (scan_other_q != CNT_MAX) begin
						scan_other_q <= scan_other_q + 16'd1;
					end
					state_q <= last_q ? ST_FOLD : ST_IDLE;
				end
				ST_FOLD: begin
					w_q          <= '0;
					wpc_q        <= '0;
					best_valid_q <= 1'b0;
					if (scan_wifi_q < 16'(min_wifi_q)) begin
						sim_q   <= '0;
						new_q   <= 1'b0;
						state_q <= ST_AVG;
					end else begin
						state_q <= ST_WPC;
					end
				end
				ST_WPC: begin
					wpc_q <= wpc_q + PW'(pop64(win_word));
					if (w_last) begin
						w_q     <= '0;
						both_q  <= '0;
						slot_q  <= '0;
						state_q <= (used_q == 3'd0) ? ST_DECIDE : ST_PRD;
					end else begin
						w_q <= w_q + WW'(1);
					end
				end
				ST_PRD: begin
					state_q <= ST_PACC;
				end
				ST_PACC: begin
					both_q <= both_nx;
					if (w_last) begin
						div_rem_q <= '0;
						div_cnt_q <= '0;
						if (wpc_q == '0) begin
							div_num_q <= '0;
							state_q   <= ST_CMP;
						end else begin
							div_num_q <= NW'(NW'(both_nx) * NW'(100));
							state_q   <= ST_DIV;
						end
					end else begin
						w_q     <= w_q + WW'(1);
						state_q <= ST_PRD;
					end
				end
				ST_DIV: begin
					if (rem_nx >= (PW + 1)'(wpc_q)) begin
						div_rem_q <= rem_nx - (PW + 1)'(wpc_q);
						div_num_q <= {div_num_q[NW-2:0], 1'b1};
					end else begin
						div_rem_q <= rem_nx;
						div_num_q <= {div_num_q[NW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(NW - 1)) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!best_valid_q || (cur_c > best_c_q)) begin
						best_valid_q <= 1'b1;
						best_c_q     <= cur_c;
						best_i_q     <= slot_q;
					end
					w_q    <= '0;
					both_q <= '0;
					if (3'(slot_q) == used_q - 3'd1) begin
						state_q <= ST_DECIDE;
					end else begin
						slot_q  <= slot_q + SLW'(1);
						state_q <= ST_PRD;
					end
				end
				ST_DECIDE: begin
					w_q <= '0;
					if (best_valid_q && (best_c_q >= match_pct_q)) begin
						idx_q   <= best_i_q;
						newp_q  <= 1'b0;
						state_q <= ST_MRD;
					end else if (used_q < 3'(PLACE_SLOTS)) begin
						idx_q   <= SLW'(used_q);
						used_q  <= used_q + 3'd1;
						newp_q  <= 1'b1;
						state_q <= ST_MRD;
					end else begin
						oldest_q <= lu_q[0];
						lru_i_q  <= '0;
						slot_q   <= SLW'(1);
						state_q  <= ST_LRU;
					end
				end
				ST_LRU: begin
					if (lru_take) begin
						oldest_q <= lu_q[slot_q];
						lru_i_q  <= slot_q;
					end
					if (slot_q == SLW'(PLACE_SLOTS - 1)) begin
						idx_q   <= lru_final;
						newp_q  <= 1'b1;
						state_q <= ST_MRD;
					end else begin
						slot_q <= slot_q + SLW'(1);
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					if (w_last) begin
						state_q <= ST_UPD;
					end else begin
						w_q     <= w_q + WW'(1);
						state_q <= ST_MRD;
					end
				end
				ST_UPD: begin
					cnt_q[idx_q] <= cnt_nx;
					lu_q[idx_q]  <= use_seq_q + 32'd1;
					use_seq_q    <= use_seq_q + 32'd1;
					cur_slot_q   <= 4'(idx_q);
					sim_q        <= best_valid_q ? best_c_q : 7'd100;
					known_q      <= cnt_nx >= 32'(known_min_q);
					new_q        <= newp_q;
					state_q      <= ST_AVG;
				end
				ST_AVG: begin
					for (int j = 0; j < 3; j++) begin
						avg_q[j] <= avg_nx[j];
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// Wait until the previous result has been taken.
					if (emit_fire) begin
						scan_wifi_q  <= '0;
						scan_other_q <= '0;
						scan_novel_q <= '0;
						win_q        <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded as the result item is posted.
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			o_place_q <= cur_slot_q;
			o_used_q  <= used_q;
			o_sim_q   <= sim_q;
			o_known_q <= known_q;
			o_new_q   <= new_q;
			o_wifi_q  <= scan_wifi_q;
			o_other_q <= scan_other_q;
			o_novel_q <= scan_novel_q;
			o_uniq_q  <= novel_total_q;
			for (int j = 0; j < 3; j++) begin
				o_avg_q[j] <= avg_q[j];
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign place_index     = signed'(o_place_q);
	assign places_used     = o_used_q;
	assign similarity      = o_sim_q;
	assign known_place     = o_known_q;
	assign fresh_place     = o_new_q;
	assign wifi_count      = o_wifi_q;
	assign other_count     = o_other_q;
	assign novel_count     = o_novel_q;
	assign unique_estimate = o_uniq_q;
	assign average_total   = o_avg_q[0];
	assign average_wifi    = o_avg_q[1];
	assign average_other   = o_avg_q[2];

endmodule

FILE: dv/tb_scan_novelty_and_place_matcher_core.sv
`timescale 1ns / 100ps

module tb_scan_novelty_and_place_matcher_core;
	import snpm_pkg::*;

	// One input item as the sender offers it.
	typedef struct {
		logic [63:0] key;
		logic        wifi;
		logic        obs;
		logic        last;
	} scan_item_t;

	// One result item, as the block reports it at the close of a scan.
	typedef struct {
		logic signed [3:0] place;
		logic [2:0]        used;
		logic [6:0]        sim;
		logic              known;
		logic              is_new;
		logic [15:0]       wifi;
		logic [15:0]       other;
		logic [15:0]       novel;
		logic [31:0]       uniq;
		logic [25:0]       avg_total;
		logic [25:0]       avg_wifi;
		logic [25:0]       avg_other;
	} scan_report_t;

	// A row of the directed table: the expected report is typed in only when
	// the row carries one, otherwise the predictor decides.
	typedef struct {
		scan_item_t   item;
		bit           typed;
		scan_report_t report;
	} directed_row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int LONG_HOLD      = 600;
	localparam int POOLS          = 10;
	localparam int POOL_KEYS      = 5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] key_hash = '0;
	logic is_wifi = 1'b0;
	logic has_observation = 1'b0;
	logic last_in_scan = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [3:0] place_index;
	logic [2:0] places_used;
	logic [6:0] similarity;
	logic known_place;
	logic fresh_place;
	logic [15:0] wifi_count;
	logic [15:0] other_count;
	logic [15:0] novel_count;
	logic [31:0] unique_estimate;
	logic [25:0] average_total;
	logic [25:0] average_wifi;
	logic [25:0] average_other;

	// The testbench clock runs with an 8 ns period.
	always #4 clk = ~clk;

	scan_novelty_and_place_matcher_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_hash        (key_hash),
		.is_wifi         (is_wifi),
		.has_observation (has_observation),
		.last_in_scan    (last_in_scan),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.place_index     (place_index),
		.places_used     (places_used),
		.similarity      (similarity),
		.known_place     (known_place),
		.fresh_place     (fresh_place),
		.wifi_count      (wifi_count),
		.other_count     (other_count),
		.novel_count     (novel_count),
		.unique_estimate (unique_estimate),
		.average_total   (average_total),
		.average_wifi    (average_wifi),
		.average_other   (average_other)
	);

	// Shadow copy of the block's state and registers, kept by the predictor.
	bit            seen_bits [BLOOM_SIZE_DEF];
	bit [255:0]    window_bits;
	bit [255:0]    place_bits [PLACE_SLOTS];
	int unsigned   scans_per_slot [PLACE_SLOTS];
	int unsigned   place_stamp [PLACE_SLOTS];
	int unsigned   slots_taken;
	logic signed [3:0] slot_now;
	int unsigned   sim_now;
	bit            known_now;
	bit            new_now;
	int unsigned   stamp_counter;
	int unsigned   cnt_wifi;
	int unsigned   cnt_other;
	int unsigned   cnt_novel;
	int unsigned   novel_sum;
	int unsigned   avg_state [3];
	int unsigned   thr_percent;
	int unsigned   thr_known;
	int unsigned   thr_wifi;
	int unsigned   avg_shift;

	scan_report_t awaited_reports [$];
	int errors = 0;

	// Shared between the stimulus and the receiver; both are written with
	// nonblocking assignments at the clock edge, so each reader sees a stable value.
	bit quiet = 1'b0;
	int long_hold_seq = 0;

	logic [63:0] key_pool [POOLS][POOL_KEYS];

	function automatic logic [63:0] mix_bloom(logic [63:0] h, int k);
		logic [63:0] x;
		x = h ^ (BLOOM_STEP * 64'(k + 1));
		x = x ^ (x >> 33);
		x = x * MIX_MULT;
		x = x ^ (x >> 33);
		return x;
	endfunction

	function automatic logic [63:0] mix_window(logic [63:0] h, int k);
		logic [63:0] x;
		x = h ^ (SIG_STEP * 64'(k + 1));
		x = x ^ (x >> 32);
		x = x * MIX_MULT;
		x = x ^ (x >> 29);
		return x;
	endfunction

	// One step of the x1000 exponential average; a falling average rounds
	// its step up, so it reaches the sample exactly.
	function automatic int unsigned smooth(int unsigned avg, int unsigned sample);
		longint a;
		longint d;
		a = longint'(avg);
		d = longint'(sample) * 1000 - a;
		if (d >= 0) begin
			a = a + (d >>> avg_shift);
		end else begin
			a = a - (((-d) + ((64'sd1 <<< avg_shift) - 1)) >>> avg_shift);
		end
		return int'(a);
	endfunction

	task automatic reset_shadow();
		foreach (seen_bits[i]) seen_bits[i] = 1'b0;
		window_bits = '0;
		foreach (place_bits[i]) begin
			place_bits[i] = '0;
			scans_per_slot[i] = 0;
			place_stamp[i] = 0;
		end
		slots_taken = 0;
		slot_now = -4'sd1;
		sim_now = 0;
		known_now = 1'b0;
		new_now = 1'b0;
		stamp_counter = 0;
		cnt_wifi = 0;
		cnt_other = 0;
		cnt_novel = 0;
		novel_sum = 0;
		foreach (avg_state[i]) avg_state[i] = 0;
		thr_percent = MATCH_PERCENT_RST;
		thr_known = KNOWN_MIN_RST;
		thr_wifi = MIN_WIFI_RST;
		avg_shift = AVG_SHIFT_RST;
	endtask

	// Folds the window of the closing scan into the best place, a free slot
	// or the least recently used slot, unless the scan had too few wifi items.
	task automatic fold_scan_window();
		int unsigned win_pop;
		int unsigned both;
		int best;
		int best_c;
		int c;
		int idx;
		int unsigned oldest;
		if (cnt_wifi < thr_wifi) begin
			sim_now = 0;
			new_now = 1'b0;
			return;
		end
		win_pop = $countones(window_bits);
		best = -1;
		best_c = -1;
		for (int i = 0; i < slots_taken; i++) begin
			both = $countones(window_bits & place_bits[i]);
			c = (win_pop != 0) ? int'(both * 100 / win_pop) : 0;
			if (c > best_c) begin
				best_c = c;
				best = i;
			end
		end
		if (best >= 0 && best_c >= int'(thr_percent)) begin
			idx = best;
			new_now = 1'b0;
		end else begin
			if (slots_taken < PLACE_SLOTS) begin
				idx = slots_taken;
				slots_taken++;
			end else begin
				// Ties go to the lowest slot; stamps compare as raw unsigned values.
				idx = 0;
				oldest = place_stamp[0];
				for (int i = 1; i < PLACE_SLOTS; i++) begin
					if (place_stamp[i] < oldest) begin
						oldest = place_stamp[i];
						idx = i;
					end
				end
			end
			place_bits[idx] = '0;
			scans_per_slot[idx] = 0;
			new_now = 1'b1;
		end
		place_bits[idx] |= window_bits;
		scans_per_slot[idx]++;
		stamp_counter++;
		place_stamp[idx] = stamp_counter;
		slot_now = 4'(idx);
		sim_now = (best_c < 0) ? 100 : best_c;
		known_now = (scans_per_slot[idx] >= thr_known);
	endtask

	// Applies one accepted item to the shadow state and returns the report
	// that it causes, if any.
	task automatic predict_scan_item(scan_item_t it, output bit closed, output scan_report_t rep);
		bit fresh;
		int unsigned total;
		logic [63:0] x;
		closed = 1'b0;
		rep = '{default: '0};
		if (it.obs) begin
			fresh = 1'b0;
			for (int k = 0; k < BLOOM_HASHES_DEF; k++) begin
				x = mix_bloom(it.key, k);
				if (!seen_bits[x[15:0]]) begin
					fresh = 1'b1;
					seen_bits[x[15:0]] = 1'b1;
				end
			end
			if (fresh) begin
				if (cnt_novel < CNT_MAX) cnt_novel++;
				novel_sum++;
			end
			if (it.wifi) begin
				if (cnt_wifi < CNT_MAX) cnt_wifi++;
				for (int k = 0; k < SIGNATURE_HASHES_DEF; k++) begin
					x = mix_window(it.key, k);
					window_bits[x[7:0]] = 1'b1;
				end
			end else if (cnt_other < CNT_MAX) begin
				cnt_other++;
			end
		end
		if (!it.last) return;
		fold_scan_window();
		total = cnt_wifi + cnt_other;
		if (total > CNT_MAX) total = CNT_MAX;
		avg_state[0] = smooth(avg_state[0], total);
		avg_state[1] = smooth(avg_state[1], cnt_wifi);
		avg_state[2] = smooth(avg_state[2], cnt_other);
		rep.place = slot_now;
		rep.used = 3'(slots_taken);
		rep.sim = 7'(sim_now);
		rep.known = known_now;
		rep.is_new = new_now;
		rep.wifi = 16'(cnt_wifi);
		rep.other = 16'(cnt_other);
		rep.novel = 16'(cnt_novel);
		rep.uniq = novel_sum;
		rep.avg_total = 26'(avg_state[0]);
		rep.avg_wifi = 26'(avg_state[1]);
		rep.avg_other = 26'(avg_state[2]);
		closed = 1'b1;
		cnt_wifi = 0;
		cnt_other = 0;
		cnt_novel = 0;
		window_bits = '0;
	endtask

	// Offers one item and holds it until the block takes it. The caller
	// stands just after a rising edge; valid is only lowered for a gap.
	task automatic send_item(scan_item_t it, bit typed, scan_report_t typed_rep);
		bit closed;
		scan_report_t rep;
		in_valid <= 1'b1;
		key_hash <= it.key;
		is_wifi <= it.wifi;
		has_observation <= it.obs;
		last_in_scan <= it.last;
		do @(posedge clk); while (!in_ready);
		predict_scan_item(it, closed, rep);
		if (closed) awaited_reports.push_back(typed ? typed_rep : rep);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [7:0] idx, logic [7:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_MATCH_PERCENT: thr_percent = value[6:0];
			REG_KNOWN_MIN: begin
				thr_known = value;
			end
			REG_MIN_WIFI: begin
				thr_wifi = value;
			end
			REG_AVG_SHIFT: begin
				avg_shift = value[3:0];
			end
			default: begin
			end
		endcase
	endtask

	// Waits until every report has come back, then lets the block finish
	// any item that causes no report.
	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_write <= 1'b0;
		@(posedge clk);
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One well-formed scan: mostly keys of one place pool, some strangers,
	// now and then an item without observation inside the scan.
	task automatic send_random_scan(int len, inout int sent);
		scan_item_t it;
		scan_report_t none;
		int pool;
		none = '{default: '0};
		pool = $urandom_range(0, POOLS - 1);
		for (int i = 0; i < len; i++) begin
			it.obs = ($urandom_range(0, 19) != 0);
			it.wifi = ($urandom_range(0, 9) < 6);
			if ($urandom_range(0, 4) == 0) begin
				it.key = {$urandom, $urandom};
			end else begin
				it.key = key_pool[pool][$urandom_range(0, POOL_KEYS - 1)];
			end
			it.last = (i == len - 1);
			send_item(it, 1'b0, none);
			sent++;
		end
	endtask

	// Every acceptance on either side restarts the watchdog.
	int stuck = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck <= 0;
		end else begin
			stuck <= stuck + 1;
			if (stuck >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// The receiver stalls in random bursts, and once for a long stretch
	// when the stimulus asks for it.
	initial begin
		int hold;
		int seen_seq;
		hold = 0;
		seen_seq = 0;
		forever begin
			@(posedge clk);
			if (long_hold_seq != seen_seq) begin
				seen_seq = long_hold_seq;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, longint unsigned exp_v,
		longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Each result item is compared with the oldest expected report.
	always @(posedge clk) begin
		scan_report_t e;
		if (out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: result item with no report expected", $realtime);
				errors++;
			end else begin
				e = awaited_reports.pop_front();
				check_field("place_index", 4'(e.place), 4'(place_index));
				check_field("places_used", e.used, places_used);
				check_field("similarity", e.sim, similarity);
				check_field("known_place", e.known, known_place);
				check_field("fresh_place", e.is_new, fresh_place);
				check_field("wifi_count", e.wifi, wifi_count);
				check_field("other_count", e.other, other_count);
				check_field("novel_count", e.novel, novel_count);
				check_field("unique_estimate", e.uniq, unique_estimate);
				check_field("average_total", e.avg_total, average_total);
				check_field("average_wifi", e.avg_wifi, average_wifi);
				check_field("average_other", e.avg_other, average_other);
			end
		end
	end

	initial begin
		directed_row_t rows [$];
		directed_row_t r;
		scan_report_t none;
		int sent;
		int phase_items;
		int len;
		int phase_cfg [6][4];

		// Register settings per phase: match percent, known scans, wifi
		// items needed, average shift. The extremes come in the first two.
		phase_cfg = '{
			'{0, 1, 1, 1}, '{100, 255, 255, 15}, '{70, 2, 3, 4},
			'{40, 5, 1, 10}, '{100, 1, 1, 2}, '{55, 3, 2, 6}
		};

		reset_shadow();
		none = '{default: '0};
		foreach (key_pool[p, k]) key_pool[p][k] = {$urandom, $urandom};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset settings. The first row closes an
		// empty scan right after reset: matching is skipped, place is -1, all else zero.
		r.item = '{64'd0, 1'b0, 1'b0, 1'b1};
		r.typed = 1'b1;
		r.report = '{default: '0};
		r.report.place = -4'sd1;
		rows.push_back(r);
		r.typed = 1'b0;
		r.report = none;
		// First place from two wifi keys at both extremes of the key.
		r.item = '{64'd0, 1'b1, 1'b1, 1'b0};                 rows.push_back(r);
		r.item = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0}; rows.push_back(r);
		// A key seen before sets no new bit.
		r.item = '{64'd0, 1'b0, 1'b1, 1'b0};                 rows.push_back(r);
		// An item without observation only acts by its last flag.
		r.item = '{64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0, 1'b0}; rows.push_back(r);
		r.item = '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 1'b1}; rows.push_back(r);
		// The same window again matches the first place, twice, until known.
		r.item = '{64'd0, 1'b1, 1'b1, 1'b0};                 rows.push_back(r);
		r.item = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1}; rows.push_back(r);
		r.item = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0}; rows.push_back(r);
		r.item = '{64'd0, 1'b1, 1'b1, 1'b1};                 rows.push_back(r);
		// One wifi item is too few, so matching is skipped.
		r.item = '{64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b1}; rows.push_back(r);
		// Only other radios: skipped as well.
		r.item = '{64'h8000_0000_0000_0001, 1'b0, 1'b1, 1'b0}; rows.push_back(r);
		r.item = '{64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b1, 1'b1}; rows.push_back(r);
		// A fresh window does not match and takes a second slot.
		r.item = '{64'hDEAD_BEEF_0000_0001, 1'b1, 1'b1, 1'b0}; rows.push_back(r);
		r.item = '{64'hDEAD_BEEF_0000_0002, 1'b1, 1'b1, 1'b0}; rows.push_back(r);
		r.item = '{64'hDEAD_BEEF_0000_0003, 1'b1, 1'b1, 1'b1}; rows.push_back(r);
		// An empty scan after places exist.
		r.item = '{64'd0, 1'b0, 1'b0, 1'b1};                 rows.push_back(r);
		foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].report);
		wait_idle();

		// Random part in phases; registers change only while idle. The
		// writes to unused indexes must leave the settings alone.
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_MATCH_PERCENT, 8'(phase_cfg[ph][0]));
			write_reg(REG_KNOWN_MIN, 8'(phase_cfg[ph][1]));
			write_reg(REG_MIN_WIFI, 8'(phase_cfg[ph][2]));
			write_reg(REG_AVG_SHIFT, 8'(phase_cfg[ph][3]));
			write_reg(8'(4 + ph * 50), 8'($urandom));
			cfg_write <= 1'b0;
			@(posedge clk);
			// The last phase runs without idling on either side.
			if (ph == 5) quiet <= 1'b1;
			phase_items = 0;
			while (phase_items < 130) begin
				// Halfway through the third phase the receiver holds off
				// long enough for the block to stall its input.
				if (ph == 2 && phase_items >= 60 && long_hold_seq == 0) begin
					long_hold_seq <= 1;
				end
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 10);
				send_random_scan(len, phase_items);
			end
			sent += phase_items;
			wait_idle();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/snpm_pkg.sv
rtl/snpm_ram.sv
rtl/scan_novelty_and_place_matcher_core.sv
dv/tb_scan_novelty_and_place_matcher_core.sv
